[design/sfr_pkg.sv]
// shared types and constants for the serial frame receiver
`timescale 1ns / 1ps

package sfr_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'hFB;
  localparam logic [7:0] HDR_SECOND = 8'h5A;

  // bytes a frame may hold before the next byte ends it with an overflow event
  localparam logic [7:0] BUF_LEN = 8'd64;

  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd100;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_TAKEN    = 3'd1;
  localparam logic [2:0] EV_GOOD     = 3'd2;
  localparam logic [2:0] EV_BAD_SUM  = 3'd3;
  localparam logic [2:0] EV_OVERFLOW = 3'd4;
  localparam logic [2:0] EV_HDR_REJ  = 3'd5;
  localparam logic [2:0] EV_DISABLED = 3'd6;
  localparam logic [2:0] EV_TIMEOUT  = 3'd7;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [0:0] REG_ENABLE       = 1'd0;
  localparam logic [0:0] REG_IDLE_TIMEOUT = 1'd1;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] byte_index;
    logic [7:0] byte_out;
    logic [7:0] frame_length;
    logic       bus_idle;
  } sfr_result_t;

endpackage

[design/sfr_core.sv]
// deframing state and the per-word step logic
`timescale 1ns / 1ps

module sfr_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic                command,
  input  logic [7:0]          data_byte,
  input  logic                enable,
  input  logic [15:0]         idle_timeout,
  output sfr_pkg::sfr_result_t result
);

  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  length_field_r, length_field_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [15:0] idle_count_r, idle_count_nxt;

  logic [16:0] idle_inc;
  logic [7:0]  cnt;
  logic [7:0]  len_eff;

  assign idle_inc = {1'b0, idle_count_r} + 17'd1;
  assign cnt      = byte_count_r + 8'd1;
  // length byte counts from the moment it arrives
  assign len_eff  = (byte_count_r == 8'd2) ? data_byte : length_field_r;

  always_comb begin
    byte_count_nxt      = byte_count_r;
    length_field_nxt    = length_field_r;
    running_sum_nxt     = running_sum_r;
    idle_count_nxt      = idle_count_r;
    result.event_res    = sfr_pkg::EV_NONE;
    result.byte_index   = 8'd0;
    result.byte_out     = 8'd0;
    result.frame_length = 8'd0;

    if (command == sfr_pkg::CMD_TICK) begin
      if (idle_inc >= {1'b0, idle_timeout}) begin
        idle_count_nxt = idle_timeout;
        if (byte_count_r != 8'd0) begin
          result.event_res    = sfr_pkg::EV_TIMEOUT;
          result.frame_length = byte_count_r;
        end
        byte_count_nxt = 8'd0;
      end else begin
        idle_count_nxt = idle_inc[15:0];
      end
    end else begin
      idle_count_nxt  = 16'd0;
      result.byte_out = data_byte;
      if (!enable) begin
        result.event_res = sfr_pkg::EV_DISABLED;
      end else begin
        result.byte_index = byte_count_r;
        if (byte_count_r >= sfr_pkg::BUF_LEN) begin
          result.event_res    = sfr_pkg::EV_OVERFLOW;
          result.frame_length = byte_count_r;
          byte_count_nxt      = 8'd0;
        end else if (byte_count_r == 8'd0) begin
          if (data_byte != sfr_pkg::HDR_FIRST) begin
            result.event_res = sfr_pkg::EV_HDR_REJ;
          end else begin
            running_sum_nxt  = 8'd0;
            length_field_nxt = 8'd0;
            byte_count_nxt   = 8'd1;
            result.event_res = sfr_pkg::EV_TAKEN;
          end
        end else if (byte_count_r == 8'd1) begin
          if (data_byte != sfr_pkg::HDR_SECOND) begin
            result.event_res = sfr_pkg::EV_HDR_REJ;
            byte_count_nxt   = 8'd0;
          end else begin
            byte_count_nxt   = 8'd2;
            result.event_res = sfr_pkg::EV_TAKEN;
          end
        end else begin
          length_field_nxt = len_eff;
          if (cnt >= len_eff) begin
            result.event_res    = (running_sum_r == data_byte) ? sfr_pkg::EV_GOOD
                                                               : sfr_pkg::EV_BAD_SUM;
            result.frame_length = cnt;
            byte_count_nxt      = 8'd0;
          end else begin
            running_sum_nxt  = running_sum_r + data_byte;
            byte_count_nxt   = cnt;
            result.event_res = sfr_pkg::EV_TAKEN;
          end
        end
      end
    end

    result.bus_idle = (idle_count_nxt >= idle_timeout);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r   <= 8'd0;
      length_field_r <= 8'd0;
      running_sum_r  <= 8'd0;
      idle_count_r   <= sfr_pkg::IDLE_TIMEOUT_RST;
    end else if (step_en) begin
      byte_count_r   <= byte_count_nxt;
      length_field_r <= length_field_nxt;
      running_sum_r  <= running_sum_nxt;
      idle_count_r   <= idle_count_nxt;
    end
  end

endmodule

[design/serial_frame_receiver.sv]
// top level: input register, deframing step and result register
`timescale 1ns / 1ps

// Serial frame receiver. Each input word is a received UART byte or a timer
// tick; frames open with 0xFB 0x5A, byte 2 gives the total length, and the
// last byte is checked against an 8-bit sum of bytes 2..L-2. Every word gives
// exactly one result word. A word goes from the input register through the
// step logic into the result register, which loads once the word is held
// and the result register has room; out_tvalid rises as it loads. One word
// per cycle is sustained while out_tready stays high; the running count, sum
// and idle counter update in the single step stage. Both registers keep
// flowing while the downstream side stalls until they are full.
module serial_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // byte_index, byte_out, frame_length, bus_idle, zero pad
  output logic [2:0]  out_tuser   // event_res
);

  logic        enable_r;
  logic [15:0] idle_timeout_r;

  logic        in_valid_r;
  logic [7:0]  in_data_r;
  logic        in_cmd_r;

  logic        out_valid_r;
  sfr_pkg::sfr_result_t out_res_r;
  sfr_pkg::sfr_result_t step_res;

  logic advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r       <= 1'b0;
      idle_timeout_r <= sfr_pkg::IDLE_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        sfr_pkg::REG_ENABLE:       enable_r       <= cfg_wdata[0];
        sfr_pkg::REG_IDLE_TIMEOUT: idle_timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // step a word when the result register has room
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_cmd_r  <= in_tuser;
    end
  end

  sfr_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (advance),
    .command      (in_cmd_r),
    .data_byte    (in_data_r),
    .enable       (enable_r),
    .idle_timeout (idle_timeout_r),
    .result       (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.event_res;
  assign out_tdata  = {7'd0, out_res_r.bus_idle, out_res_r.frame_length,
                       out_res_r.byte_out, out_res_r.byte_index};

endmodule
